// File: rtl/sawl_pkg.sv
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared field widths, opcode and lifecycle codes, and the command and
// table-entry types passed between the front end and the back end.
// ----------------------------------------------------------------------------
package sawl_pkg;

  localparam int SLOT_W  = 8;   // slot index width
  localparam int STATE_W = 3;   // lifecycle code width
  localparam int OP_W    = 2;   // opcode width
  localparam int CNT_W   = 9;   // slot count / free count width

  // opcodes
  localparam logic [OP_W-1:0] OP_RESERVE    = 2'd0;
  localparam logic [OP_W-1:0] OP_TRANSITION = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE    = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY      = 2'd3;

  // lifecycle codes
  localparam logic [STATE_W-1:0] ST_FREE       = 3'd0;
  localparam logic [STATE_W-1:0] ST_RESERVED   = 3'd1;
  localparam logic [STATE_W-1:0] ST_QHIGH      = 3'd2;
  localparam logic [STATE_W-1:0] ST_QNORMAL    = 3'd3;
  localparam logic [STATE_W-1:0] ST_DISPATCHED = 3'd4;
  localparam logic [STATE_W-1:0] ST_PROCESSING = 3'd5;
  localparam logic [STATE_W-1:0] ST_RESPONDED  = 3'd6;

  // classified command, front end to back end
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  idx;
    logic [STATE_W-1:0] req;
    logic               valid;   // idx below the slot count
  } cmd_t;

  // one slot table entry: lifecycle state and free-stack link
  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [SLOT_W-1:0]  link;
  } entry_t;

  // number of usable slots: the table depth, capped at 256 for the 9-bit count
  function automatic logic [CNT_W-1:0] slot_cap(input int max_slots);
    logic [CNT_W-1:0] cap;
    cap = (max_slots < 256) ? CNT_W'(max_slots) : CNT_W'(256);
    return cap;
  endfunction

endpackage

// File: rtl/sawl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sawl_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

endmodule

// File: rtl/sawl_front.sv
// ----------------------------------------------------------------------------
// Slot allocator front end
// Accepts commands, checks the slot index against the slot count and
// holds classified commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sawl_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sawl_pkg::OP_W-1:0]     opcode,
  input  logic [sawl_pkg::SLOT_W-1:0]   slot_id,
  input  logic [sawl_pkg::STATE_W-1:0]  requested_state,
  input  logic [sawl_pkg::CNT_W-1:0]    slots,
  output logic                          busy,
  output logic                          head_valid,
  output sawl_pkg::cmd_t                head,
  input  logic                          pop
);

  sawl_pkg::cmd_t q [2];
  sawl_pkg::cmd_t in_cmd;
  logic [1:0]     count;
  logic           wr_ptr;
  logic           rd_ptr;
  logic           push;

  assign busy       = (count == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  always_comb begin
    in_cmd.op    = opcode;
    in_cmd.idx   = slot_id;
    in_cmd.req   = requested_state;
    in_cmd.valid = ({1'b0, slot_id} < slots);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        q[wr_ptr] <= in_cmd;
        wr_ptr    <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && count == 2'd2 && !pop))
    else $error("front queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("front queue popped while empty");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("front queue count lost a transfer");
`endif

endmodule

// File: rtl/sawl_back.sv
// ----------------------------------------------------------------------------
// Slot allocator back end
// Executes one command at a time: issue a table read, then update the
// table, the free stack and the counters, and register the result.
// ----------------------------------------------------------------------------
module sawl_back #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rebuild,
  input  logic [sawl_pkg::CNT_W-1:0]    rebuild_count,
  input  logic [sawl_pkg::CNT_W-1:0]    slots,
  input  logic                          cmd_valid,
  input  sawl_pkg::cmd_t                cmd,
  output logic                          pop,
  output logic                          done,
  output logic                          ok,
  output logic [sawl_pkg::SLOT_W-1:0]   granted_slot,
  output logic [sawl_pkg::STATE_W-1:0]  slot_status,
  output logic [sawl_pkg::CNT_W-1:0]    free_slots
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [sawl_pkg::CNT_W-1:0] CAP = sawl_pkg::slot_cap(MAX_SLOTS);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                        state;
  sawl_pkg::cmd_t                cur_cmd;
  logic [sawl_pkg::SLOT_W-1:0]   stack_top;
  logic [sawl_pkg::SLOT_W-1:0]   stack_top_next;
  logic [sawl_pkg::CNT_W-1:0]    fresh;        // slots below this were handed out
  logic [sawl_pkg::CNT_W-1:0]    fresh_next;
  logic [sawl_pkg::CNT_W-1:0]    free_total;
  logic [sawl_pkg::CNT_W-1:0]    free_next;

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [AW-1:0]                 raddr;
  sawl_pkg::entry_t              wdata;
  sawl_pkg::entry_t              rdata;

  logic [sawl_pkg::STATE_W-1:0]  cur_state;
  logic                          pushed;       // top came from a release
  logic                          res_ok;
  logic [sawl_pkg::SLOT_W-1:0]   res_grant;
  logic [sawl_pkg::STATE_W-1:0]  res_status;

  function automatic logic allowed(input logic [sawl_pkg::STATE_W-1:0] cur,
                                   input logic [sawl_pkg::STATE_W-1:0] nxt);
    logic a;
    case (cur) inside
      sawl_pkg::ST_RESERVED:
        a = (nxt == sawl_pkg::ST_QHIGH) || (nxt == sawl_pkg::ST_QNORMAL);
      sawl_pkg::ST_QHIGH, sawl_pkg::ST_QNORMAL:
        a = (nxt == sawl_pkg::ST_DISPATCHED);
      sawl_pkg::ST_DISPATCHED:
        a = (nxt == sawl_pkg::ST_PROCESSING);
      sawl_pkg::ST_PROCESSING:
        a = (nxt == sawl_pkg::ST_RESPONDED);
      default:
        a = 1'b0;
    endcase
    return a;
  endfunction

  sawl_ram #(
    .WIDTH ($bits(sawl_pkg::entry_t)),
    .DEPTH (MAX_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pop   = (state == S_IDLE) && cmd_valid;
  assign raddr = (cmd.op == sawl_pkg::OP_RESERVE) ? AW'(stack_top) : AW'(cmd.idx);

  // entries at or above the fill mark were never touched since the rebuild
  assign cur_state = ({1'b0, cur_cmd.idx} < fresh) ? rdata.state : sawl_pkg::ST_FREE;
  assign pushed    = ({1'b0, free_total} + {1'b0, fresh}) > {1'b0, slots};

  always_comb begin
    we             = 1'b0;
    waddr          = AW'(cur_cmd.idx);
    wdata          = rdata;
    stack_top_next = stack_top;
    fresh_next     = fresh;
    free_next      = free_total;
    res_ok         = 1'b0;
    res_grant      = '0;
    res_status     = sawl_pkg::ST_FREE;
    unique case (cur_cmd.op)
      sawl_pkg::OP_RESERVE: begin
        if (free_total != '0) begin
          we          = 1'b1;
          waddr       = AW'(stack_top);
          wdata.state = sawl_pkg::ST_RESERVED;
          if (pushed) begin
            stack_top_next = rdata.link;
          end else begin
            fresh_next     = fresh + 1'b1;
            stack_top_next = sawl_pkg::SLOT_W'(fresh + 1'b1);
          end
          free_next  = free_total - 1'b1;
          res_ok     = 1'b1;
          res_grant  = stack_top;
          res_status = sawl_pkg::ST_RESERVED;
        end
      end
      sawl_pkg::OP_TRANSITION: begin
        if (cur_cmd.valid) begin
          if (allowed(cur_state, cur_cmd.req)) begin
            we          = 1'b1;
            wdata.state = cur_cmd.req;
            res_ok      = 1'b1;
            res_status  = cur_cmd.req;
          end else begin
            res_status  = cur_state;
          end
        end
      end
      sawl_pkg::OP_RELEASE: begin
        if (cur_cmd.valid && cur_state != sawl_pkg::ST_FREE) begin
          we             = 1'b1;
          wdata.state    = sawl_pkg::ST_FREE;
          wdata.link     = stack_top;
          stack_top_next = cur_cmd.idx;
          free_next      = free_total + 1'b1;
          res_ok         = 1'b1;
        end
      end
      sawl_pkg::OP_QUERY: begin
        res_ok = 1'b1;
        if (cur_cmd.valid) begin
          res_status = cur_state;
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
    if (state != S_EXEC) begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      stack_top  <= '0;
      fresh      <= '0;
      free_total <= CAP;
    end else if (rebuild) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      stack_top  <= '0;
      fresh      <= '0;
      free_total <= rebuild_count;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_cmd <= cmd;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          stack_top    <= stack_top_next;
          fresh        <= fresh_next;
          free_total   <= free_next;
          done         <= 1'b1;
          ok           <= res_ok;
          granted_slot <= res_grant;
          slot_status  <= res_status;
          free_slots   <= free_next;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    free_total <= slots)
    else $error("free count above slot count");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fresh <= slots)
    else $error("fill mark above slot count");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result without an executed command");

  a_pop_starts_exec: assert property (@(posedge clk) disable iff (rst || rebuild)
    pop |=> state == S_EXEC)
    else $error("popped command not executed");
`endif

endmodule

// File: rtl/slot_allocator_with_lifecycle.sv
// ----------------------------------------------------------------------------
// Slot allocator with lifecycle tracking
// Free slots live on a linked stack in an on-chip table; every slot also
// carries a lifecycle state that moves along a fixed set of transitions.
// ----------------------------------------------------------------------------
// Usage:
//   Commands: drive opcode, slot_id and requested_state with start high;
//   a transfer takes place at a clock edge where start is high and busy is
//   low. busy rises only when the two-entry command queue is full.
//   Results: done is high for exactly one cycle with ok, granted_slot,
//   slot_status and free_slots; results come out in command order and
//   the receiver has no way to hold them off.
//   Flow: a transfer enters the command queue; the back end takes the
//   queue head into its execute state, then registers the result.
//   It takes no new command before the last one is done, as the slot
//   table read is followed by its write-back (one read and one write port).
//   Configuration: APB register 0 (byte address 0) is slots_in_use; a
//   write rebuilds the pool (all slots free, chain 0..n-1).
//   Counts above the table depth saturate. Write it only while idle.
//   Reset: synchronous, active high; leaves the pool at its full size with
//   every slot free and is ready in the next cycle. No table clearing
//   pass: a fill mark tells untouched slots apart from written ones.
// ----------------------------------------------------------------------------
module slot_allocator_with_lifecycle #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [sawl_pkg::OP_W-1:0]     opcode,
  input  logic [sawl_pkg::SLOT_W-1:0]   slot_id,
  input  logic [sawl_pkg::STATE_W-1:0]  requested_state,
  // result channel
  output logic                          done,
  output logic                          ok,
  output logic [sawl_pkg::SLOT_W-1:0]   granted_slot,
  output logic [sawl_pkg::STATE_W-1:0]  slot_status,
  output logic [sawl_pkg::CNT_W-1:0]    free_slots,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam logic [sawl_pkg::CNT_W-1:0] CAP = sawl_pkg::slot_cap(MAX_SLOTS);

  logic [sawl_pkg::CNT_W-1:0] slots_in_use;
  logic [sawl_pkg::CNT_W-1:0] slots_wr;
  logic                       cfg_wr;
  logic                       head_valid;
  logic                       pop;
  sawl_pkg::cmd_t             head;

  // register 0 decodes on word address bit; byte offset bits are ignored
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && !paddr[2];
  assign slots_wr = (pwdata[sawl_pkg::CNT_W-1:0] > CAP) ? CAP
                                                        : pwdata[sawl_pkg::CNT_W-1:0];
  assign prdata   = paddr[2] ? 32'd0 : {{(32 - sawl_pkg::CNT_W){1'b0}}, slots_in_use};

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= CAP;
    end else if (cfg_wr) begin
      slots_in_use <= slots_wr;
    end
  end

  // front: accept and classify, queue toward the back end
  sawl_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .opcode          (opcode),
    .slot_id         (slot_id),
    .requested_state (requested_state),
    .slots           (slots_in_use),
    .busy            (busy),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop)
  );

  // back: table read, update, result register
  sawl_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .rebuild       (cfg_wr),
    .rebuild_count (slots_wr),
    .slots         (slots_in_use),
    .cmd_valid     (head_valid),
    .cmd           (head),
    .pop           (pop),
    .done          (done),
    .ok            (ok),
    .granted_slot  (granted_slot),
    .slot_status   (slot_status),
    .free_slots    (free_slots)
  );

endmodule
